### hdl/bayer_green_balance_7x7_macros.svh
// assertion helpers shared by the block
`ifndef BAYER_GREEN_BALANCE_7X7_MACROS_SVH
`define BAYER_GREEN_BALANCE_7X7_MACROS_SVH

// checked outside reset
`define BGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/bgb_pkg.sv
`default_nettype none
package bgb_pkg;

  localparam int unsigned MAX_WIDTH  = 8192;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned WID_W      = 14;
  localparam int unsigned HGT_W      = 13;
  localparam int unsigned DRN_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DAT_W  = 14;
  localparam int unsigned N_PAIRS    = 36;
  localparam int unsigned N_GROUPS   = 6;
  localparam int unsigned GRP_SIZE   = 6;
  localparam logic [PIX_W-1:0] PIX_MAX    = 12'd4095;
  localparam logic [WID_W-1:0] MIN_DIM    = 14'd8;
  localparam logic [5:0]       MIN_COUNT  = 6'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;

  localparam logic [5:0] RECIP_LUT [32] = '{
    6'd51, 6'd43, 6'd37, 6'd32, 6'd28, 6'd26, 6'd23, 6'd21,
    6'd20, 6'd18, 6'd17, 6'd16, 6'd15, 6'd14, 6'd13, 6'd13,
    6'd12, 6'd12, 6'd11, 6'd11, 6'd10, 6'd10, 6'd9,  6'd9,
    6'd9,  6'd9,  6'd8,  6'd8,  6'd8,  6'd8,  6'd7,  6'd7
  };

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RD, S_WR, S_D1, S_D2, S_D3, S_M1, S_M2, S_FIN,
    S_PASS, S_DA, S_DB, S_DC, S_DD, S_OUT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic rd_line;
    logic shift;
    logic d1;
    logic d2;
    logic d3;
    logic m1;
    logic m2;
    logic fin;
    logic pass;
    logic dr_a;
    logic dr_b;
    logic rd_drain;
    logic dr_d;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic enable;
    logic dc_zero;
    logic corr;
    logic prod;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [2:0] ar;
    logic [2:0] ac;
    logic [2:0] br;
    logic [2:0] bc;
  } pair_t;

  function automatic logic [2:0] sub_idx(input int unsigned i);
    return (2 * i + 1 > 6) ? 3'd6 : 3'(2 * i + 1);
  endfunction

  function automatic pair_t mk_pair(input logic rb, input int unsigned li,
                                    input int unsigned lj, input int unsigned ri,
                                    input int unsigned rj);
    pair_t p;
    p.ar = sub_idx(li);
    p.ac = rb ? 3'(2 * lj) : sub_idx(lj);
    p.br = 3'(2 * ri);
    p.bc = rb ? sub_idx(rj) : 3'(2 * rj);
    return p;
  endfunction

  // window coordinates of neighbour pair k for either phase
  function automatic pair_t pair_pos(input logic rb, input int unsigned k);
    pair_t p;
    int unsigned n;
    p = '0;
    n = 0;
    for (int unsigned i = 0; i < 3; i++) begin
      if (rb) begin
        if (n == k) p = mk_pair(rb, i, 0, i, 0);
        n++;
        if (n == k) p = mk_pair(rb, i, 0, i + 1, 0);
        n++;
        if (n == k) p = mk_pair(rb, i, 3, i, 2);
        n++;
        if (n == k) p = mk_pair(rb, i, 3, i + 1, 2);
        n++;
        for (int unsigned j = 1; j < 3; j++) begin
          if (n == k) p = mk_pair(rb, i, j, i, j - 1);
          n++;
          if (n == k) p = mk_pair(rb, i, j, i, j);
          n++;
          if (n == k) p = mk_pair(rb, i, j, i + 1, j - 1);
          n++;
          if (n == k) p = mk_pair(rb, i, j, i + 1, j);
          n++;
        end
      end else begin
        for (int unsigned j = 0; j < 3; j++) begin
          if (n == k) p = mk_pair(rb, i, j, i, j);
          n++;
          if (n == k) p = mk_pair(rb, i, j, i, j + 1);
          n++;
          if (n == k) p = mk_pair(rb, i, j, i + 1, j);
          n++;
          if (n == k) p = mk_pair(rb, i, j, i + 1, j + 1);
          n++;
        end
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

### hdl/bgb_if.sv
`default_nettype none
interface bgb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [bgb_pkg::PIX_W-1:0]   raw_pix;
  modport source (output valid, output opcode, output raw_pix, input ready);
  modport sink   (input valid, input opcode, input raw_pix, output ready);
endinterface

interface bgb_out_if;
  logic                        valid;
  logic                        ready;
  logic [bgb_pkg::PIX_W-1:0]   bal_pix;
  logic                        frame_last;
  modport source (output valid, output bal_pix, output frame_last, input ready);
  modport sink   (input valid, input bal_pix, input frame_last, output ready);
endinterface

interface bgb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bgb_pkg::CFG_IDX_W-1:0]   index;
  logic [bgb_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/bayer_green_balance_7x7.sv
// Bayer green-balance filter over a 7x7 window, 12-bit raw pixels in raster order.
// in_i carries one item per handshake: opcode 0 is a pixel, opcode 1 a drain tick.
// out_o carries balanced pixels with frame_last on the final pixel of a frame.
// cfg_i writes one register per handshake and is always ready; write it only
// while the block is idle.
// With enable set, output lags input by 3*W+3 pixel positions; drain ticks after
// the frame flush the remaining pixels. With enable clear, pixels echo directly.
// A corrected interior centre adds correction steps to the border-pixel path
// (diff, two adder-tree levels, two multiplies, rounding); a drain tick runs its
// address and read steps, and a tick with nothing left to flush ends at decode;
// the next item is taken once the sequencer returns to idle. The line buffer is
// one 8192-deep memory with six lanes, read and written once per pixel.
// A finished result sits in the output register; if the receiver stalls, one
// further item is taken and held until that register frees up.
// Reset clears counters, pending drain and registers to their defaults; the line
// buffer and window are not cleared and need no clearing pass.
`default_nettype none
`include "bayer_green_balance_7x7_macros.svh"
module bayer_green_balance_7x7 (
  input wire logic clk_i,
  input wire logic rst_ni,
  bgb_in_if.sink   in_i,
  bgb_out_if.source out_o,
  bgb_cfg_if.sink  cfg_i
);

  bgb_pkg::cmd_t cmd;
  bgb_pkg::sts_t sts;

  assign in_i.ready  = cmd.in_ready;
  assign cfg_i.ready = 1'b1;

  bgb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bgb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_opcode_i (in_i.opcode),
    .in_pixel_i  (in_i.raw_pix),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_pixel_o (out_o.bal_pix),
    .out_last_o  (out_o.frame_last)
  );

  `BGB_ASSERT(a_busy_after_accept, (in_i.valid && in_i.ready) |=> !in_i.ready, "ready after accept")
  `BGB_ASSERT(a_out_from_load, $rose(out_o.valid) |-> $past(cmd.out_load), "output without load")
  `BGB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_o.valid, "output valid in reset")

endmodule
`default_nettype wire

### hdl/bgb_ctrl.sv
`default_nettype none
module bgb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire bgb_pkg::sts_t sts_i,
  output bgb_pkg::cmd_t      cmd_o
);

  bgb_pkg::state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bgb_pkg::S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    unique case (st_q)
      bgb_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          st_d = bgb_pkg::S_DEC;
        end
      end
      bgb_pkg::S_DEC: begin
        if (sts_i.op) begin
          st_d = sts_i.dc_zero ? bgb_pkg::S_IDLE : bgb_pkg::S_DA;
        end else begin
          st_d = sts_i.enable ? bgb_pkg::S_RD : bgb_pkg::S_PASS;
        end
      end
      bgb_pkg::S_RD: begin
        cmd_o.rd_line = 1'b1;
        st_d = bgb_pkg::S_WR;
      end
      bgb_pkg::S_WR: begin
        cmd_o.shift = 1'b1;
        st_d = bgb_pkg::S_OUT;
      end
      bgb_pkg::S_D1: begin
        cmd_o.d1 = 1'b1;
        st_d = bgb_pkg::S_D2;
      end
      bgb_pkg::S_D2: begin
        cmd_o.d2 = 1'b1;
        st_d = bgb_pkg::S_D3;
      end
      bgb_pkg::S_D3: begin
        cmd_o.d3 = 1'b1;
        st_d = bgb_pkg::S_M1;
      end
      bgb_pkg::S_M1: begin
        cmd_o.m1 = 1'b1;
        st_d = bgb_pkg::S_M2;
      end
      bgb_pkg::S_M2: begin
        cmd_o.m2 = 1'b1;
        st_d = bgb_pkg::S_FIN;
      end
      bgb_pkg::S_FIN: begin
        cmd_o.fin = 1'b1;
        st_d = bgb_pkg::S_OUT;
      end
      bgb_pkg::S_PASS: begin
        cmd_o.pass = 1'b1;
        st_d = bgb_pkg::S_OUT;
      end
      bgb_pkg::S_DA: begin
        cmd_o.dr_a = 1'b1;
        st_d = bgb_pkg::S_DB;
      end
      bgb_pkg::S_DB: begin
        cmd_o.dr_b = 1'b1;
        st_d = bgb_pkg::S_DC;
      end
      bgb_pkg::S_DC: begin
        cmd_o.rd_drain = 1'b1;
        st_d = bgb_pkg::S_DD;
      end
      bgb_pkg::S_DD: begin
        cmd_o.dr_d = 1'b1;
        st_d = bgb_pkg::S_OUT;
      end
      bgb_pkg::S_OUT: begin
        // interior centres detour through the correction steps first
        if (sts_i.corr) begin
          st_d = bgb_pkg::S_D1;
        end else if (!sts_i.prod) begin
          st_d = bgb_pkg::S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          st_d = bgb_pkg::S_IDLE;
        end
      end
      default: st_d = bgb_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/bgb_dp.sv
`default_nettype none
module bgb_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bgb_pkg::cmd_t                   cmd_i,
  output bgb_pkg::sts_t                        sts_o,
  input  wire logic                            in_opcode_i,
  input  wire logic [bgb_pkg::PIX_W-1:0]       in_pixel_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic [bgb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bgb_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [bgb_pkg::PIX_W-1:0]            out_pixel_o,
  output logic                                 out_last_o
);

  // configuration
  logic                         enable_q;
  logic [1:0]                   pattern_q;
  logic [bgb_pkg::WID_W-1:0]    fw_q;
  logic [bgb_pkg::HGT_W-1:0]    fh_q;
  logic [3:0]                   low_q;
  logic [5:0]                   high_q;
  logic [9:0]                   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      pattern_q <= 2'd0;
      fw_q      <= 14'd1920;
      fh_q      <= 13'd1080;
      low_q     <= 4'd5;
      high_q    <= 6'd20;
      thr_q     <= 10'd128;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bgb_pkg::REG_ENABLE:    enable_q  <= cfg_data_i[0];
        bgb_pkg::REG_PATTERN:   pattern_q <= cfg_data_i[1:0];
        bgb_pkg::REG_WIDTH:     fw_q      <= cfg_data_i;
        bgb_pkg::REG_HEIGHT:    fh_q      <= cfg_data_i[12:0];
        bgb_pkg::REG_LOW:       low_q     <= cfg_data_i[3:0];
        bgb_pkg::REG_HIGH:      high_q    <= cfg_data_i[5:0];
        bgb_pkg::REG_THRESHOLD: thr_q     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic [bgb_pkg::WID_W-1:0] w;
  logic [bgb_pkg::HGT_W-1:0] h;
  logic [bgb_pkg::DRN_W-1:0] total;

  always_comb begin
    if (fw_q < bgb_pkg::MIN_DIM) begin
      w = bgb_pkg::MIN_DIM;
    end else if (fw_q > bgb_pkg::WID_W'(bgb_pkg::MAX_WIDTH)) begin
      w = bgb_pkg::WID_W'(bgb_pkg::MAX_WIDTH);
    end else begin
      w = fw_q;
    end
    h = (fh_q < bgb_pkg::HGT_W'(bgb_pkg::MIN_DIM)) ? bgb_pkg::HGT_W'(bgb_pkg::MIN_DIM) : fh_q;
    total = bgb_pkg::DRN_W'({w, 1'b0}) + bgb_pkg::DRN_W'(w) + 15'd3;
  end

  // item capture and position counters
  logic                          op_q;
  logic [bgb_pkg::PIX_W-1:0]     pix_q;
  logic [bgb_pkg::ADDR_W-1:0]    col_q, row_q;
  logic [bgb_pkg::DRN_W-1:0]     dc_q;
  logic                          line_end, frame_end;

  assign line_end  = ({1'b0, col_q} + 14'd1) >= w;
  assign frame_end = line_end && (({1'b0, row_q} + 14'd1) >= {1'b0, h});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_opcode_i;
      pix_q <= in_pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      dc_q  <= '0;
    end else if (cmd_i.shift || cmd_i.pass) begin
      if (line_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + 13'd1;
      end else begin
        col_q <= col_q + 13'd1;
      end
      dc_q <= (frame_end && cmd_i.shift) ? total : '0;
    end else if (cmd_i.dr_d) begin
      dc_q <= dc_q - 15'd1;
    end
  end

  // line buffers, one row of six lanes per column
  logic [5:0][bgb_pkg::PIX_W-1:0] mem [bgb_pkg::MAX_WIDTH];
  logic [5:0][bgb_pkg::PIX_W-1:0] rdata_q, wdata;
  logic [bgb_pkg::ADDR_W-1:0]     raddr, dcol_q;

  assign raddr = cmd_i.rd_drain ? dcol_q : col_q;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      wdata[k] = rdata_q[k + 1];
    end
    wdata[5] = pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      mem[col_q] <= wdata;
    end
    if (cmd_i.rd_line || cmd_i.rd_drain) begin
      rdata_q <= mem[raddr];
    end
  end

  // 7x7 window
  logic [6:0][6:0][bgb_pkg::PIX_W-1:0] win_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int k = 0; k < 7; k++) begin
        for (int l = 0; l < 6; l++) begin
          win_q[k][l] <= win_q[k][l + 1];
        end
      end
      for (int k = 0; k < 6; k++) begin
        win_q[k][6] <= rdata_q[k];
      end
      win_q[6][6] <= pix_q;
    end
  end

  // result staging
  logic                      corr_q, rb_q, prod_q, last_q;
  logic [bgb_pkg::PIX_W-1:0] val_q;
  logic [bgb_pkg::PIX_W-1:0] res_clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= 1'b0;
      prod_q <= 1'b0;
    end else if (cmd_i.shift) begin
      corr_q <= (row_q > 13'd5) && (col_q > 13'd5);
      prod_q <= (row_q > 13'd3) || ((row_q == 13'd3) && (col_q > 13'd2));
    end else if (cmd_i.d1) begin
      corr_q <= 1'b0;
    end else if (cmd_i.pass || cmd_i.dr_d) begin
      prod_q <= 1'b1;
    end
  end

  // drain addressing
  logic [bgb_pkg::DRN_W-1:0]     d_q, e;
  logic                          dwin_q;
  logic [2:0]                    ln_q;

  assign e = d_q - 15'd3;

  always_ff @(posedge clk_i) begin
    if (cmd_i.dr_a) begin
      d_q <= (dc_q > total) ? '0 : total - dc_q;
    end
    if (cmd_i.dr_b) begin
      dwin_q <= d_q < 15'd3;
      if (e < bgb_pkg::DRN_W'(w)) begin
        ln_q   <= 3'd3;
        dcol_q <= bgb_pkg::ADDR_W'(e);
      end else if (e < bgb_pkg::DRN_W'({w, 1'b0})) begin
        ln_q   <= 3'd4;
        dcol_q <= bgb_pkg::ADDR_W'(e - bgb_pkg::DRN_W'(w));
      end else begin
        ln_q   <= 3'd5;
        dcol_q <= bgb_pkg::ADDR_W'(e - bgb_pkg::DRN_W'({w, 1'b0}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      val_q  <= win_q[3][4];
      last_q <= 1'b0;
      rb_q   <= ~(row_q[0] ^ col_q[0]) ^ (pattern_q[1] ^ pattern_q[0]);
    end else if (cmd_i.pass) begin
      val_q  <= pix_q;
      last_q <= frame_end;
    end else if (cmd_i.dr_d) begin
      val_q  <= dwin_q ? win_q[3][3'd4 + 3'(d_q[1:0])] : rdata_q[ln_q];
      last_q <= dc_q == 15'd1;
    end else if (cmd_i.fin) begin
      val_q  <= res_clip;
    end
  end

  // neighbour pair differences
  logic [bgb_pkg::PIX_W-1:0] pa [bgb_pkg::N_PAIRS];
  logic [bgb_pkg::PIX_W-1:0] pb [bgb_pkg::N_PAIRS];

  for (genvar k = 0; k < bgb_pkg::N_PAIRS; k++) begin : g_pair
    localparam bgb_pkg::pair_t P0 = bgb_pkg::pair_pos(1'b0, k);
    localparam bgb_pkg::pair_t P1 = bgb_pkg::pair_pos(1'b1, k);
    assign pa[k] = rb_q ? win_q[P1.ar][P1.ac] : win_q[P0.ar][P0.ac];
    assign pb[k] = rb_q ? win_q[P1.br][P1.bc] : win_q[P0.br][P0.bc];
  end

  logic signed [12:0] diff_q [bgb_pkg::N_PAIRS];
  logic [bgb_pkg::N_PAIRS-1:0] vld_q;
  logic signed [15:0] psum_q [bgb_pkg::N_GROUPS];
  logic [2:0]         pcnt_q [bgb_pkg::N_GROUPS];
  logic signed [18:0] sum_q;
  logic [5:0]         cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.d1) begin
      for (int k = 0; k < bgb_pkg::N_PAIRS; k++) begin
        logic signed [12:0] df;
        logic [11:0]        ad;
        df = $signed({1'b0, pa[k]}) - $signed({1'b0, pb[k]});
        ad = df[12] ? 12'(-df) : 12'(df);
        vld_q[k]  <= ad < {2'b00, thr_q};
        diff_q[k] <= (ad < {2'b00, thr_q}) ? df : '0;
      end
    end
    if (cmd_i.d2) begin
      for (int g = 0; g < bgb_pkg::N_GROUPS; g++) begin
        logic signed [15:0] s;
        logic [2:0]         c;
        s = '0;
        c = '0;
        for (int t = 0; t < bgb_pkg::GRP_SIZE; t++) begin
          s = s + 16'(diff_q[g * bgb_pkg::GRP_SIZE + t]);
          c = c + 3'(vld_q[g * bgb_pkg::GRP_SIZE + t]);
        end
        psum_q[g] <= s;
        pcnt_q[g] <= c;
      end
    end
    if (cmd_i.d3) begin
      logic signed [18:0] s;
      logic [5:0]         c;
      s = '0;
      c = '0;
      for (int g = 0; g < bgb_pkg::N_GROUPS; g++) begin
        s = s + 19'(psum_q[g]);
        c = c + 6'(pcnt_q[g]);
      end
      sum_q <= s;
      cnt_q <= c;
    end
  end

  // scaling by reciprocal with ramp
  logic        zero_q, neg_q, full_q;
  logic [5:0]  ramp_q;
  logic [23:0] p1_q;
  logic [29:0] p2_q;
  logic [17:0] mag;
  logic [5:0]  lutv;

  assign mag  = 18'(sum_q[18] ? -sum_q : sum_q);
  assign lutv = bgb_pkg::RECIP_LUT[5'(cnt_q - bgb_pkg::MIN_COUNT)];

  always_ff @(posedge clk_i) begin
    if (cmd_i.m1) begin
      zero_q <= (cnt_q < bgb_pkg::MIN_COUNT) || (cnt_q < {2'b00, low_q});
      neg_q  <= sum_q[18];
      full_q <= cnt_q >= high_q;
      ramp_q <= cnt_q - {2'b00, low_q};
      p1_q   <= 24'(mag) * 24'(lutv);
    end
    if (cmd_i.m2) begin
      p2_q <= 30'(ramp_q) * 30'(p1_q);
    end
  end

  logic [18:0]        q;
  logic [18:0]        hmag;
  logic signed [20:0] res;

  always_comb begin
    if (zero_q) begin
      q = '0;
    end else if (full_q) begin
      q = 19'(p1_q >> 8);
    end else begin
      q = 19'((23'(p2_q >> 8) + 23'd8) >> 4);
    end
    if (neg_q && !zero_q) begin
      hmag = 19'((20'(q) + 20'd1) >> 1);
      res  = $signed({9'd0, win_q[3][3]}) + $signed({2'b00, hmag});
    end else begin
      hmag = q >> 1;
      res  = $signed({9'd0, win_q[3][3]}) - $signed({2'b00, hmag});
    end
    if (res < 0) begin
      res_clip = '0;
    end else if (res > $signed({9'd0, bgb_pkg::PIX_MAX})) begin
      res_clip = bgb_pkg::PIX_MAX;
    end else begin
      res_clip = res[11:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pixel_o <= val_q;
      out_last_o  <= last_q;
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.enable   = enable_q;
    sts_o.dc_zero  = dc_q == '0;
    sts_o.corr     = corr_q;
    sts_o.prod     = prod_q;
    sts_o.out_free = !out_valid_o || out_ready_i;
  end

endmodule
`default_nettype wire
